// ===== hw/rtl/source_text_tokenizer_defines.svh =====
// ---------------------------------------------------------------------------
// Source text tokenizer assertion macros
// Shared concurrent assertion forms used by the tokenizer checker.
// ---------------------------------------------------------------------------
`ifndef SOURCE_TEXT_TOKENIZER_DEFINES_SVH
`define SOURCE_TEXT_TOKENIZER_DEFINES_SVH

// Property checked on every clock edge outside of reset.
`define STT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Property that is also checked while reset is applied.
`define STT_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ===== hw/rtl/stt_pkg.sv =====
// ---------------------------------------------------------------------------
// Source text tokenizer package
// Shared widths, token codes, result record and keyword helpers.
// ---------------------------------------------------------------------------
package stt_pkg;

   // Width of the running byte offset; offsets wrap at this width.
   localparam int OFFSET_BITS = 16;
   localparam int LEN_BITS    = 16;
   localparam int START_BITS  = 16;
   localparam int KIND_BITS   = 5;
   localparam int PREFIX_BYTES = 5;

   localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

   // Result queue geometry.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   typedef logic [OFFSET_BITS-1:0]    offset_type;
   typedef logic [LEN_BITS-1:0]       len_type;
   typedef logic [KIND_BITS-1:0]      kind_type;
   typedef logic [8*PREFIX_BYTES-1:0] prefix_type;

   localparam kind_type KIND_IDENT  = 5'd0;
   localparam kind_type KIND_VAR    = 5'd1;
   localparam kind_type KIND_FN     = 5'd2;
   localparam kind_type KIND_BOOL   = 5'd3;
   localparam kind_type KIND_NIL    = 5'd4;
   localparam kind_type KIND_NUMBER = 5'd5;
   localparam kind_type KIND_ADD    = 5'd6;
   localparam kind_type KIND_SUB    = 5'd7;
   localparam kind_type KIND_MUL    = 5'd8;
   localparam kind_type KIND_DIV    = 5'd9;
   localparam kind_type KIND_EQUALS = 5'd10;
   localparam kind_type KIND_DOT    = 5'd11;
   localparam kind_type KIND_COMMA  = 5'd12;
   localparam kind_type KIND_LPAREN = 5'd13;
   localparam kind_type KIND_RPAREN = 5'd14;
   localparam kind_type KIND_LBRACE = 5'd15;
   localparam kind_type KIND_RBRACE = 5'd16;

   // Keywords packed with their first byte in the low bits.
   localparam prefix_type KW_VAR   = 40'h00_0072_6176;
   localparam prefix_type KW_FN    = 40'h00_0000_6E66;
   localparam prefix_type KW_TRUE  = 40'h00_6575_7274;
   localparam prefix_type KW_FALSE = 40'h65_736C_6166;
   localparam prefix_type KW_NIL   = 40'h00_006C_696E;

   typedef enum logic [1:0] {
      MODE_NONE = 2'd0,
      MODE_WORD = 2'd1,
      MODE_NUM  = 2'd2
   } mode_type;

   typedef struct packed {
      kind_type              kind;
      logic [START_BITS-1:0] start;
      len_type               length;
      logic                  last;
   } tok_type;

   // Up to two results produced by one accepted request.
   typedef struct packed {
      tok_type    tok0;
      tok_type    tok1;
      logic [1:0] count;
   } scan_out_type;

   function automatic kind_type word_kind(prefix_type prefix, len_type len);
      kind_type k;
      k = KIND_IDENT;
      if (len == len_type'(3) && prefix == KW_VAR) k = KIND_VAR;
      else if (len == len_type'(2) && prefix == KW_FN) k = KIND_FN;
      else if (len == len_type'(4) && prefix == KW_TRUE) k = KIND_BOOL;
      else if (len == len_type'(5) && prefix == KW_FALSE) k = KIND_BOOL;
      else if (len == len_type'(3) && prefix == KW_NIL) k = KIND_NIL;
      return k;
   endfunction

   // Reports an offset modulo 2^START_BITS.
   function automatic logic [START_BITS-1:0] to_start(offset_type off);
      logic [31:0] wide;
      wide = 32'(off);
      return wide[START_BITS-1:0];
   endfunction

endpackage

// ===== hw/rtl/stt_scanner.sv =====
// ---------------------------------------------------------------------------
// Tokenizer scanner
// Holds the pending run and byte offset and classifies one byte per cycle in which step is high.
// ---------------------------------------------------------------------------
module stt_scanner (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           ch,
   input  logic                 end_of_text,
   output stt_pkg::scan_out_type scan_out
);
   import stt_pkg::*;

   mode_type   mode_ff, mode_in;
   offset_type start_ff, start_in;
   len_type    len_ff, len_in;
   prefix_type prefix_ff, prefix_in;
   offset_type offset_ff, offset_in;

   logic     letter, digit, sym_hit, cont;
   logic     have_old, have_sym, have_eot, have_new;
   kind_type sym_kind;
   tok_type  tok_old, tok_new;

   always_comb begin
      sym_hit  = 1'b1;
      sym_kind = KIND_ADD;
      case (ch)
         "+": sym_kind = KIND_ADD;
         "-": sym_kind = KIND_SUB;
         "*": sym_kind = KIND_MUL;
         "/": sym_kind = KIND_DIV;
         "=": sym_kind = KIND_EQUALS;
         ".": sym_kind = KIND_DOT;
         ",": sym_kind = KIND_COMMA;
         "(": sym_kind = KIND_LPAREN;
         ")": sym_kind = KIND_RPAREN;
         "{": sym_kind = KIND_LBRACE;
         "}": sym_kind = KIND_RBRACE;
         default: sym_hit = 1'b0;
      endcase
   end

   always_comb begin
      letter = (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z");
      digit  = (ch >= "0" && ch <= "9");
      cont   = (mode_ff == MODE_WORD && (letter || digit)) ||
               (mode_ff == MODE_NUM && digit);

      // Run that this byte ends.
      have_old       = !cont && (mode_ff == MODE_WORD || mode_ff == MODE_NUM);
      tok_old.kind   = (mode_ff == MODE_WORD) ? word_kind(prefix_ff, len_ff) : KIND_NUMBER;
      tok_old.start  = to_start(start_ff);
      tok_old.length = len_ff;
      tok_old.last   = 1'b0;

      mode_in   = mode_ff;
      start_in  = start_ff;
      len_in    = len_ff;
      prefix_in = prefix_ff;

      if (cont) begin
         for (int i = 0; i < PREFIX_BYTES; i++) begin
            if (len_ff == len_type'(i)) begin
               prefix_in[8*i +: 8] = ch;
            end
         end
         if (len_ff != LEN_MAX) begin
            len_in = len_ff + len_type'(1);
         end
      end else if (letter || digit) begin
         mode_in   = letter ? MODE_WORD : MODE_NUM;
         start_in  = offset_ff;
         len_in    = len_type'(1);
         prefix_in = prefix_type'(ch);
      end else begin
         mode_in   = MODE_NONE;
         len_in    = '0;
         prefix_in = '0;
      end

      have_sym = !cont && !letter && !digit && sym_hit;
      have_eot = end_of_text && (mode_in == MODE_WORD || mode_in == MODE_NUM);
      have_new = have_sym || have_eot;

      if (have_sym) begin
         tok_new.kind   = sym_kind;
         tok_new.start  = to_start(offset_ff);
         tok_new.length = len_type'(1);
      end else begin
         tok_new.kind   = (mode_in == MODE_WORD) ? word_kind(prefix_in, len_in) : KIND_NUMBER;
         tok_new.start  = to_start(start_in);
         tok_new.length = len_in;
      end
      tok_new.last = 1'b1;

      if (end_of_text) begin
         mode_in   = MODE_NONE;
         len_in    = '0;
         prefix_in = '0;
         offset_in = '0;
      end else begin
         offset_in = offset_ff + offset_type'(1);
      end

      scan_out.tok0      = have_old ? tok_old : tok_new;
      scan_out.tok0.last = !(have_old && have_new);
      scan_out.tok1      = tok_new;
      scan_out.count     = {1'b0, have_old} + {1'b0, have_new};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_NONE;
         start_ff  <= '0;
         len_ff    <= '0;
         prefix_ff <= '0;
         offset_ff <= '0;
      end else if (step) begin
         mode_ff   <= mode_in;
         start_ff  <= start_in;
         len_ff    <= len_in;
         prefix_ff <= prefix_in;
         offset_ff <= offset_in;
      end
   end

endmodule

// ===== hw/rtl/stt_result_queue.sv =====
// ---------------------------------------------------------------------------
// Tokenizer result queue
// Small circular buffer taking up to two tokens a cycle, issuing one when not stalled.
// ---------------------------------------------------------------------------
module stt_result_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  stt_pkg::scan_out_type scan_out,
   output logic                  room,
   output logic                  out_valid,
   input  logic                  out_stall,
   output stt_pkg::tok_type      out_tok
);
   import stt_pkg::*;

   tok_type               entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]  wr_ptr_second;
   logic [QCNT_BITS-1:0]  count_ff, count_in;
   logic [QCNT_BITS-1:0]  n_push;
   logic                  pop;

   function automatic logic [QPTR_BITS-1:0] ptr_next(logic [QPTR_BITS-1:0] p);
      return (p == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_BITS'(1);
   endfunction

   always_comb begin
      room          = (count_ff <= QCNT_BITS'(QUEUE_DEPTH - 2));
      out_valid     = (count_ff != '0);
      out_tok       = entry_ff[rd_ptr_ff];
      pop           = out_valid && !out_stall;
      n_push        = push ? QCNT_BITS'(scan_out.count) : '0;
      wr_ptr_second = ptr_next(wr_ptr_ff);
      rd_ptr_in     = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      case (n_push)
         QCNT_BITS'(1): wr_ptr_in = wr_ptr_second;
         QCNT_BITS'(2): wr_ptr_in = ptr_next(wr_ptr_second);
         default:       wr_ptr_in = wr_ptr_ff;
      endcase
      count_in = count_ff + n_push - QCNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (n_push != '0) begin
         entry_ff[wr_ptr_ff] <= scan_out.tok0;
      end
      if (n_push == QCNT_BITS'(2)) begin
         entry_ff[wr_ptr_second] <= scan_out.tok1;
      end
   end

endmodule

// ===== hw/rtl/source_text_tokenizer.sv =====
// ---------------------------------------------------------------------------
// Source text tokenizer
// Byte-serial lexer emitting tokens as kind, start offset and length.
// ---------------------------------------------------------------------------
// Usage: each request carries one byte of source text on req_ch, with
// req_end_of_text set on the final byte of a text. A request is taken at a
// clock edge where req_valid is high and req_stall is low. Each byte yields
// zero, one or two tokens on the rsp_ channel, in text order; rsp_last marks
// the final token caused by a byte. A token is taken at an edge where
// rsp_valid is high and rsp_stall is low.
// A token is written into the result queue when the request that ends it is
// taken. Throughput: one byte per cycle while each byte makes at most one
// token and rsp_stall is low; the single response port sets the limit, so a
// byte that closes a run and also yields a symbol queues two tokens.
// Stall: the four-entry result queue keeps taking bytes while tokens wait;
// req_stall rises once fewer than two entries are free. rsp_ payload holds
// steady while rsp_stall is high.
// Reset clears the pending run, the byte offset and the queue; the first
// byte after reset is at offset 0, as is the first byte after end of text.
// ---------------------------------------------------------------------------
module source_text_tokenizer (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [7:0]                         req_ch,
   input  logic                               req_end_of_text,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output stt_pkg::kind_type                  rsp_kind,
   output logic [stt_pkg::START_BITS-1:0]     rsp_start_res,
   output stt_pkg::len_type                   rsp_length,
   output logic                               rsp_last
);
   import stt_pkg::*;

   scan_out_type scan_out;
   tok_type      out_tok;
   logic         room;
   logic         step;

   // A byte is only taken when the queue can hold both tokens it might cause.
   assign req_stall = !room;
   assign step      = req_valid && room;

   stt_scanner u_scanner (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .ch          (req_ch),
      .end_of_text (req_end_of_text),
      .scan_out    (scan_out)
   );

   stt_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (step),
      .scan_out  (scan_out),
      .room      (room),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_tok   (out_tok)
   );

   assign rsp_kind      = out_tok.kind;
   assign rsp_start_res = out_tok.start;
   assign rsp_length    = out_tok.length;
   assign rsp_last      = out_tok.last;

endmodule

// ===== hw/rtl/stt_checker.sv =====
// ---------------------------------------------------------------------------
// Tokenizer port checker
// Watches the top-level ports and flags token or handshake slips.
// ---------------------------------------------------------------------------
`include "source_text_tokenizer_defines.svh"

module stt_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input stt_pkg::kind_type              rsp_kind,
   input logic [stt_pkg::START_BITS-1:0] rsp_start_res,
   input stt_pkg::len_type               rsp_length,
   input logic                           rsp_last
);
   import stt_pkg::*;

   // The queue is empty right after reset.
   `STT_ASSERT_RST(a_reset_empty, reset |=> !rsp_valid, "response valid after reset")

   // A waiting token keeps its payload until taken.
   `STT_ASSERT(a_rsp_hold,
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_start_res)
         && $stable(rsp_length) && $stable(rsp_last),
      "stalled token changed")

   // Symbols are always one byte long; runs are never empty.
   `STT_ASSERT(a_sym_len,
      rsp_valid && rsp_kind >= KIND_ADD |-> rsp_length == len_type'(1),
      "symbol token length not one")
   `STT_ASSERT(a_len_nonzero,
      rsp_valid |-> rsp_length != '0 && rsp_kind <= KIND_RBRACE,
      "bad token kind or length")

   // The request stall follows the queue fill alone, so an empty queue never
   // holds off a request.
   `STT_ASSERT(a_no_idle_stall, !rsp_valid |-> !req_stall, "request stalled with empty queue")

endmodule

bind source_text_tokenizer stt_checker u_checker (.*);

// ===== tb/tb.sv =====
// ---------------------------------------------------------------------------
// Source text tokenizer testbench
// Feeds byte streams into the tokenizer and checks every token it returns
// against a cycle-free model of the lexer kept inside this bench. Requests
// are offered in random bursts and results are stalled on a pattern of the
// receiver's own, with one long output hold that backs up the result queue.
// ---------------------------------------------------------------------------
module tb;
   import stt_pkg::*;

   // A long run of no handshakes on either channel means the block is hung.
   // The longest correct quiet stretch is the deliberate output hold below.
   localparam int RSP_HOLD_CYCLES = 400;
   localparam int WATCHDOG_LIMIT  = 4000;
   // The block answers from a registered result queue; a few spare cycles are
   // enough to catch a stray token after the last expected one.
   localparam int SETTLE_CYCLES   = 8;
   localparam int LONG_RUN_BYTES  = 60;

   logic             clock           = 1'b0;
   logic             reset           = 1'b1;
   logic             req_valid       = 1'b0;
   logic             req_stall;
   logic [7:0]       req_ch          = 8'h00;
   logic             req_end_of_text = 1'b0;
   logic             rsp_valid;
   logic             rsp_stall       = 1'b0;
   kind_type         rsp_kind;
   logic [START_BITS-1:0] rsp_start_res;
   len_type          rsp_length;
   logic             rsp_last;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   source_text_tokenizer DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_ch          (req_ch),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_start_res   (rsp_start_res),
      .rsp_length      (rsp_length),
      .rsp_last        (rsp_last)
   );

   // -------------------------------------------------------------------------
   // Lexer model. It mirrors the pending run and the running byte offset, and
   // every accepted request appends the tokens it causes to expected_tokens.
   // -------------------------------------------------------------------------
   mode_type   pend_mode   = MODE_NONE;
   offset_type pend_start  = '0;
   len_type    pend_len    = '0;
   prefix_type pend_prefix = '0;
   offset_type text_offset = '0;

   tok_type    step_tokens[$];
   tok_type    expected_tokens[$];

   int errors         = 0;
   int bytes_sent     = 0;
   int tokens_checked = 0;

   // Packs a word the way the run prefix holds it: first byte lowest.
   function automatic prefix_type pack_word(input string s);
      prefix_type v;
      v = '0;
      for (int i = 0; i < s.len() && i < PREFIX_BYTES; i++)
         v[8*i +: 8] = s[i];
      return v;
   endfunction

   // A word is a keyword only on an exact match of both length and bytes.
   function automatic kind_type keyword_kind(input prefix_type p, input len_type n);
      kind_type k;
      k = KIND_IDENT;
      if (n == 16'd2 && p == pack_word("fn"))
         k = KIND_FN;
      else if (n == 16'd3 && p == pack_word("var"))
         k = KIND_VAR;
      else if (n == 16'd3 && p == pack_word("nil"))
         k = KIND_NIL;
      else if ((n == 16'd4 && p == pack_word("true")) ||
               (n == 16'd5 && p == pack_word("false")))
         k = KIND_BOOL;
      return k;
   endfunction

   function automatic bit symbol_kind(input logic [7:0] c, output kind_type k);
      bit found;
      found = 1'b1;
      k     = KIND_IDENT;
      case (c)
         "+": k = KIND_ADD;
         "-": k = KIND_SUB;
         "*": k = KIND_MUL;
         "/": k = KIND_DIV;
         "=": k = KIND_EQUALS;
         ".": k = KIND_DOT;
         ",": k = KIND_COMMA;
         "(": k = KIND_LPAREN;
         ")": k = KIND_RPAREN;
         "{": k = KIND_LBRACE;
         "}": k = KIND_RBRACE;
         default: found = 1'b0;
      endcase
      return found;
   endfunction

   function automatic void add_token(input kind_type k, input offset_type start,
                                     input len_type n);
      tok_type t;
      t.kind   = k;
      t.start  = start;
      t.length = n;
      t.last   = 1'b0;
      step_tokens = {step_tokens, t};
   endfunction

   function automatic void close_pending();
      if (pend_mode == MODE_WORD)
         add_token(keyword_kind(pend_prefix, pend_len), pend_start, pend_len);
      else if (pend_mode == MODE_NUM)
         add_token(KIND_NUMBER, pend_start, pend_len);
      pend_mode   = MODE_NONE;
      pend_len    = '0;
      pend_prefix = '0;
   endfunction

   function automatic void open_pending(input mode_type m, input logic [7:0] c);
      pend_mode   = m;
      pend_start  = text_offset;
      pend_len    = 16'd1;
      pend_prefix = prefix_type'(c);
   endfunction

   // Only the first five bytes are kept; the length stops at all ones.
   function automatic void grow_pending(input logic [7:0] c);
      int idx;
      idx = int'(pend_len);
      if (idx < PREFIX_BYTES)
         pend_prefix[8*idx +: 8] = c;
      if (pend_len != '1)
         pend_len = pend_len + 16'd1;
   endfunction

   function automatic void predict_byte(input logic [7:0] c, input logic eot);
      bit       letter;
      bit       digit;
      bit       is_sym;
      kind_type sym;
      letter = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
      digit  = (c >= "0" && c <= "9");
      is_sym = symbol_kind(c, sym);
      step_tokens.delete();

      if (pend_mode == MODE_WORD && (letter || digit)) begin
         grow_pending(c);
      end else if (pend_mode == MODE_NUM && digit) begin
         grow_pending(c);
      end else begin
         // Anything else ends the run; whitespace and unknown bytes are
         // then simply dropped.
         close_pending();
         if (letter)
            open_pending(MODE_WORD, c);
         else if (digit)
            open_pending(MODE_NUM, c);
         else if (is_sym)
            add_token(sym, text_offset, 16'd1);
      end

      // End of text flushes whatever is pending, even a run opened by this
      // very byte, and the next text starts again at offset zero.
      if (eot) begin
         close_pending();
         text_offset = '0;
      end else begin
         text_offset = text_offset + 1'b1;
      end

      if (step_tokens.size() > 0)
         step_tokens[step_tokens.size()-1].last = 1'b1;
      expected_tokens = {expected_tokens, step_tokens};
   endfunction

   // -------------------------------------------------------------------------
   // Request side. Requests go out in bursts of random length separated by
   // random gaps; a maximum gap of zero keeps req_valid high throughout.
   // -------------------------------------------------------------------------
   int sender_max_gap = 0;
   int burst_left     = 0;
   bit offering       = 1'b0;

   task automatic send_byte(input logic [7:0] c, input logic eot);
      req_valid       <= 1'b1;
      req_ch          <= c;
      req_end_of_text <= eot;
      offering = 1'b1;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      predict_byte(c, eot);
      bytes_sent++;
      if (sender_max_gap != 0) begin
         if (burst_left == 0) begin
            req_valid <= 1'b0;
            offering = 1'b0;
            repeat ($urandom_range(sender_max_gap, 1))
               @(posedge clock);
            burst_left = $urandom_range(16, 1);
         end else begin
            burst_left--;
         end
      end
   endtask

   task automatic send_text(input string s, input bit eot_on_last);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i], eot_on_last && (i == s.len() - 1));
   endtask

   // Drops req_valid, waits for every predicted token to come back, and lets
   // a few more cycles pass so a stray token would still be seen.
   task automatic wait_for_tokens();
      if (offering) begin
         req_valid <= 1'b0;
         offering = 1'b0;
      end
      while (expected_tokens.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES)
         @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Result side. The receiver stalls at a phase-dependent rate, but whenever
   // bit 5 of its cycle counter is set it takes everything, and a test may ask
   // for a hold during which it stalls without a break.
   // -------------------------------------------------------------------------
   int          rsp_stall_pct = 0;
   int          rsp_hold_left = 0;
   logic [31:0] rx_cycle      = '0;

   always @(posedge clock) begin
      rx_cycle <= rx_cycle + 1;
      if (rsp_hold_left > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold_left = rsp_hold_left - 1;
      end else if (rx_cycle[5]) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99, 0) < rsp_stall_pct);
      end
   end

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: token %s mismatch, expected %0d, actual %0d",
                  $time, name, want, got);
         errors++;
      end
   endfunction

   // Every accepted token is matched against the oldest prediction.
   always @(posedge clock) begin : check_tokens
      tok_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_tokens.size() == 0) begin
            $display("%0t: unexpected token, expected none, actual kind %0d start %0d",
                     $time, rsp_kind, rsp_start_res);
            errors++;
         end else begin
            want = expected_tokens.pop_front();
            check_field("kind", 16'(want.kind), 16'(rsp_kind));
            check_field("start", 16'(want.start), 16'(rsp_start_res));
            check_field("length", 16'(want.length), 16'(rsp_length));
            check_field("last", 16'(want.last), 16'(rsp_last));
            tokens_checked++;
         end
      end
   end

   // The watchdog ends a hung run: it counts cycles in which neither a
   // request nor a token is accepted.
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles = quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Every single-byte symbol, with a keyword ended by the first of them so
   // one request yields both the run and the symbol.
   task automatic test_token_classes();
      send_text("nil+-*/=.,(){}", 1'b0);
      wait_for_tokens();
   endtask

   // The byte extremes: NUL, all ones, the first byte above ASCII, DEL and
   // the edges of the whitespace range; NUL, all ones and DEL end pending runs.
   task automatic test_byte_extremes();
      send_text("Z9", 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte("0", 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte("q", 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte(8'h09, 1'b0);
      send_byte(8'h0D, 1'b0);
      wait_for_tokens();
   endtask

   // End of text on a byte that ends a number and opens a word (two
   // tokens), on a one-byte word, and on whitespace with nothing pending.
   task automatic test_end_of_text();
      send_text("12", 1'b0);
      send_byte("x", 1'b1);
      send_byte("a", 1'b1);
      send_byte(" ", 1'b1);
      wait_for_tokens();
   endtask

   // The receiver holds off for a long stretch while requests keep coming;
   // each word-plus-symbol pair needs two result slots, so the queue fills.
   task automatic test_backpressure();
      sender_max_gap = 0;
      rsp_stall_pct  = 0;
      rsp_hold_left  = RSP_HOLD_CYCLES;
      for (int i = 0; i < 20; i++) begin
         send_byte("a" + 8'(i), 1'b0);
         send_byte((i % 2) ? "+" : "}", 1'b0);
      end
      wait_for_tokens();
   endtask

   // Runs much longer than the five bytes kept for keyword matching: a word
   // that starts like a keyword must still come back as an identifier with
   // its full length, and a long number run follows a symbol.
   task automatic test_long_run();
      sender_max_gap = 0;
      rsp_stall_pct  = 0;
      send_byte(" ", 1'b1);
      send_text("false", 1'b0);
      for (int i = 0; i < LONG_RUN_BYTES; i++)
         send_byte((i % 3 == 0) ? "7" : "k", 1'b0);
      send_byte("+", 1'b0);
      for (int i = 0; i < LONG_RUN_BYTES; i++)
         send_byte("0" + 8'(i % 10), 1'b0);
      send_byte(" ", 1'b1);
      wait_for_tokens();
   endtask

   function automatic logic [7:0] random_letter();
      logic [7:0] base;
      base = $urandom_range(1, 0) ? "a" : "A";
      return base + 8'($urandom_range(25, 0));
   endfunction

   function automatic logic [7:0] random_word_byte();
      if ($urandom_range(3, 0) == 0)
         return "0" + 8'($urandom_range(9, 0));
      return random_letter();
   endfunction

   // Mostly well-formed text: keywords and near misses of them, identifiers,
   // numbers and symbols, with whitespace, noise bytes and end-of-text marks
   // scattered in. Each phase uses its own idling on both channels.
   task automatic test_random_text(input int total_bytes);
      string      keywords[5];
      string      symbols;
      logic [7:0] spaces[6];
      string      s;
      int         phase_start;
      int         pick;
      int         n;
      int         pos;
      bit         eot;
      keywords = '{"var", "fn", "true", "false", "nil"};
      symbols  = "+-*/=.,(){}";
      spaces   = '{8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20};

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_max_gap = 0;  rsp_stall_pct = 0;  end
            1: begin sender_max_gap = 6;  rsp_stall_pct = 30; end
            2: begin sender_max_gap = 0;  rsp_stall_pct = 70; end
            default: begin sender_max_gap = 12; rsp_stall_pct = 50; end
         endcase
         burst_left  = $urandom_range(16, 1);
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < total_bytes / 4) begin
            pick = $urandom_range(99, 0);
            eot  = ($urandom_range(24, 0) == 0);
            if (pick < 22) begin
               s = keywords[$urandom_range(4, 0)];
               case ($urandom_range(3, 0))
                  0: s = s.substr(0, s.len() - 2);
                  1: begin
                     pos = $urandom_range(s.len() - 1, 0);
                     s.putc(pos, s[pos] ^ 8'h20);
                  end
                  default: ;
               endcase
               if ($urandom_range(4, 0) == 0) begin
                  send_text(s, 1'b0);
                  send_byte(random_word_byte(), eot);
               end else begin
                  send_text(s, eot);
               end
            end else if (pick < 44) begin
               n = ($urandom_range(7, 0) == 0) ? $urandom_range(12, 6) : $urandom_range(5, 1);
               send_byte(random_letter(), eot && n == 1);
               for (int k = 1; k < n; k++)
                  send_byte(random_word_byte(), eot && k == n - 1);
            end else if (pick < 58) begin
               n = $urandom_range(6, 1);
               for (int k = 0; k < n; k++)
                  send_byte("0" + 8'($urandom_range(9, 0)), eot && k == n - 1);
            end else if (pick < 80) begin
               send_byte(symbols[$urandom_range(10, 0)], eot);
            end else if (pick < 88) begin
               send_byte(spaces[$urandom_range(5, 0)], eot);
            end else begin
               send_byte(8'($urandom_range(255, 0)), eot);
            end
            // Words left without a separator merge with what follows.
            if ($urandom_range(1, 0))
               send_byte(spaces[$urandom_range(5, 0)], 1'b0);
         end
         wait_for_tokens();
      end
   endtask

   initial begin
      repeat (6)
         @(posedge clock);
      reset <= 1'b0;

      test_token_classes();
      test_byte_extremes();
      test_end_of_text();
      test_backpressure();
      test_random_text(1750);
      test_long_run();

      $display("Sent %0d text bytes and checked %0d tokens: keywords, near misses, symbols,",
               bytes_sent, tokens_checked);
      $display("noise and end-of-text bytes, a long output hold and runs past the kept prefix.");
      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
